// ===== rtl/psb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psb_pkg;

  localparam int RCP_K = 22;
  localparam int DIV_W = 23;

  localparam logic [1:0] OP_WR_PAL = 2'd0;
  localparam logic [1:0] OP_WR_PIX = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  localparam logic [2:0] REG_SCR_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SCR_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd2;
  localparam logic [2:0] REG_RED_SHIFT    = 3'd3;
  localparam logic [2:0] REG_GREEN_SHIFT  = 3'd4;
  localparam logic [2:0] REG_BLUE_SHIFT   = 3'd5;
  localparam logic [2:0] REG_SCALE_FORCED = 3'd6;
  localparam logic [2:0] REG_SCALE_FACTOR = 3'd7;

  localparam logic [7:0] MASK_R565 = 8'hF8;
  localparam logic [7:0] MASK_G565 = 8'hFC;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  palette_slot;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] frame_address;
    logic [7:0]  color_index;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        in_picture;
  } out_t;

  typedef struct packed {
    logic [11:0] scr_width;
    logic [11:0] scr_height;
    logic        pixel_format;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic        scale_forced;
    logic [4:0]  scale_factor;
  } cfg_t;

  typedef struct packed {
    logic [11:0]      tw;
    logic [11:0]      th;
    logic [11:0]      xo;
    logic [11:0]      yo;
    logic [DIV_W-1:0] rw;
    logic [DIV_W-1:0] rh;
  } geom_t;

  function automatic logic [31:0] pack_pixel(cfg_t c, logic [23:0] rgb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    if (!c.pixel_format) begin
      return {16'd0, r[7:3] & MASK_R565[7:3], g[7:2] & MASK_G565[7:2], b[7:3]};
    end
    return ({24'd0, r} << c.red_shift) | ({24'd0, g} << c.green_shift) |
           ({24'd0, b} << c.blue_shift);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata <= mem_r[addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psb_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psb_geom #(
  parameter int SRC_WIDTH  = 320,
  parameter int SRC_HEIGHT = 200
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire psb_pkg::cfg_t cfg,
  output psb_pkg::geom_t     geom,
  output logic               busy
);

  localparam logic [2:0] G_FIT  = 3'd0;
  localparam logic [2:0] G_DIV  = 3'd1;
  localparam logic [2:0] G_TGT  = 3'd2;
  localparam logic [2:0] G_RW   = 3'd3;
  localparam logic [2:0] G_RH   = 3'd4;
  localparam logic [2:0] G_IDLE = 3'd5;
  localparam logic [2:0] G_QF   = 3'd6;

  localparam int DW = psb_pkg::DIV_W;
  localparam logic [DW-1:0] RCP_ONE = DW'(1) << psb_pkg::RCP_K;

  // constant reciprocals, exact floor for numerators below 2^22
  localparam int CSH = 33;
  localparam logic [29:0] INV_SW =
    30'(((64'd1 << CSH) + 64'(SRC_WIDTH) - 64'd1) / 64'(SRC_WIDTH));
  localparam logic [29:0] INV_SH =
    30'(((64'd1 << CSH) + 64'(SRC_HEIGHT) - 64'd1) / 64'(SRC_HEIGHT));

  logic [2:0]    state_r;
  logic [2:0]    ret_r;
  logic [4:0]    cnt_r;
  logic [DW-1:0] dq_r;
  logic [11:0]   dvs_r;
  logic [11:0]   rem_r;
  logic          cond_r;
  psb_pkg::geom_t geom_r;

  logic [21:0] wsh;
  logic [21:0] hsw;
  logic        cond;
  logic [51:0] fq_prod;
  logic [12:0] sh;
  logic        ge;
  logic [11:0] fitw;
  logic [11:0] fith;
  logic [4:0]  fct;
  logic [15:0] ttw;
  logic [15:0] tth;
  logic [11:0] tw_nxt;
  logic [11:0] th_nxt;

  always_comb begin
    wsh  = {10'd0, cfg.scr_width} * 22'(SRC_HEIGHT);
    hsw  = {10'd0, cfg.scr_height} * 22'(SRC_WIDTH);
    cond = wsh <= hsw;
    fq_prod = {30'd0, dq_r[21:0]} * {22'd0, (cond_r ? INV_SW : INV_SH)};
    sh   = {rem_r, dq_r[DW-1]};
    ge   = sh >= {1'b0, dvs_r};
    fitw = cond_r ? cfg.scr_width : dq_r[11:0];
    fith = cond_r ? dq_r[11:0] : cfg.scr_height;
    fct  = (cfg.scale_factor == 5'd0) ? 5'd1 : cfg.scale_factor;
    if (cfg.scale_forced) begin
      ttw = {11'd0, fct} * 16'(SRC_WIDTH);
      tth = {11'd0, fct} * 16'(SRC_HEIGHT);
    end else begin
      ttw = {4'd0, fitw};
      tth = {4'd0, fith};
    end
    if (ttw == 16'd0) begin
      ttw = 16'd1;
    end
    if (tth == 16'd0) begin
      tth = 16'd1;
    end
    if (ttw > {4'd0, cfg.scr_width} || tth > {4'd0, cfg.scr_height}) begin
      tw_nxt = fitw;
      th_nxt = fith;
    end else begin
      tw_nxt = ttw[11:0];
      th_nxt = tth[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_FIT;
    end else if (start) begin
      state_r <= G_FIT;
    end else begin
      unique case (state_r)
        G_FIT: begin
          dq_r    <= DW'(cond ? wsh : hsw);
          cond_r  <= cond;
          state_r <= G_QF;
        end
        G_QF: begin
          dq_r    <= DW'(fq_prod[51:CSH]);
          state_r <= G_TGT;
        end
        G_DIV: begin
          rem_r <= ge ? 12'(sh - {1'b0, dvs_r}) : sh[11:0];
          dq_r  <= {dq_r[DW-2:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DW - 1)) begin
            state_r <= ret_r;
          end
        end
        G_TGT: begin
          geom_r.tw <= tw_nxt;
          geom_r.th <= th_nxt;
          geom_r.xo <= (cfg.scr_width - tw_nxt) >> 1;
          geom_r.yo <= (cfg.scr_height - th_nxt) >> 1;
          dq_r      <= RCP_ONE;
          dvs_r     <= tw_nxt;
          rem_r     <= '0;
          cnt_r     <= '0;
          ret_r     <= G_RW;
          state_r   <= G_DIV;
        end
        G_RW: begin
          geom_r.rw <= dq_r;
          dq_r      <= RCP_ONE;
          dvs_r     <= geom_r.th;
          rem_r     <= '0;
          cnt_r     <= '0;
          ret_r     <= G_RH;
          state_r   <= G_DIV;
        end
        G_RH: begin
          geom_r.rh <= dq_r;
          state_r   <= G_IDLE;
        end
        G_IDLE: begin
          state_r <= G_IDLE;
        end
        default: begin
          state_r <= G_FIT;
        end
      endcase
    end
  end

  assign geom = geom_r;
  assign busy = state_r != G_IDLE;

endmodule
`default_nettype wire

// ===== rtl/psb_fetch.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psb_fetch #(
  parameter int SRC_WIDTH       = 320,
  parameter int SRC_HEIGHT      = 200,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           hold,
  input  wire psb_pkg::cfg_t  cfg,
  input  wire psb_pkg::geom_t geom,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire psb_pkg::in_t   in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output psb_pkg::out_t       out_item
);

  localparam int FRAME = SRC_WIDTH * SRC_HEIGHT;
  localparam int FAW   = $clog2(FRAME);
  localparam int PAW   = $clog2(PALETTE_ENTRIES);
  localparam int K     = psb_pkg::RCP_K;
  localparam int DW    = psb_pkg::DIV_W;

  logic adv;
  logic acc;

  logic [8:1] v_r;
  psb_pkg::in_t it_r [8:1];
  logic [8:1] ins_r;

  logic [11:0] dx1_r, dy1_r;
  logic [21:0] ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;
  logic [11:0] qx3_r, qy3_r, qx4_r, qy4_r;
  logic [23:0] px4_r, py4_r;
  logic [11:0] sx5_r, sy5_r;
  logic [FAW-1:0] pos6_r;
  logic        pok8_r;

  logic          out_valid_r;
  psb_pkg::out_t out_r;

  logic [44:0] prx, pry;
  logic [23:0] rx, ry;
  logic [23:0] posw;
  logic [FAW-1:0] f_addr;
  logic        f_we;
  logic [7:0]  f_q;
  logic [PAW-1:0] p_addr;
  logic        p_we;
  logic [23:0] p_q;
  logic [11:0] dx0, dy0;
  logic        ins0;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !hold;
  assign acc      = in_valid && in_ready;

  always_comb begin
    dx0  = in_item.out_x - geom.xo;
    dy0  = in_item.out_y - geom.yo;
    ins0 = in_item.out_x < cfg.scr_width && in_item.out_y < cfg.scr_height &&
           in_item.out_x >= geom.xo && in_item.out_y >= geom.yo &&
           dx0 < geom.tw && dy0 < geom.th;
    prx  = {23'd0, ax2_r} * {22'd0, geom.rw};
    pry  = {23'd0, ay2_r} * {22'd0, geom.rh};
    rx   = {2'd0, ax4_r} - px4_r;
    ry   = {2'd0, ay4_r} - py4_r;
    posw = {12'd0, sy5_r} * 24'(SRC_WIDTH) + {12'd0, sx5_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[7:1], acc};
      out_valid_r <= v_r[8] && it_r[8].opcode == psb_pkg::OP_FETCH;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[1] <= in_item;
      ins_r[1] <= ins0;
      dx1_r <= dx0;
      dy1_r <= dy0;
      for (int i = 2; i <= 8; i++) begin
        it_r[i]  <= it_r[i-1];
        ins_r[i] <= ins_r[i-1];
      end
      ax2_r <= {10'd0, dx1_r} * 22'(SRC_WIDTH);
      ay2_r <= {10'd0, dy1_r} * 22'(SRC_HEIGHT);
      qx3_r <= prx[K+11:K];
      qy3_r <= pry[K+11:K];
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      px4_r <= {12'd0, qx3_r} * {12'd0, geom.tw};
      py4_r <= {12'd0, qy3_r} * {12'd0, geom.th};
      qx4_r <= qx3_r;
      qy4_r <= qy3_r;
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;
      sx5_r <= qx4_r + {11'd0, rx >= {12'd0, geom.tw}};
      sy5_r <= qy4_r + {11'd0, ry >= {12'd0, geom.th}};
      pos6_r <= posw[FAW-1:0];
      pok8_r <= 32'(f_q) < 32'(PALETTE_ENTRIES);
      out_r.in_picture <= ins_r[8];
      out_r.pixel_word <= (ins_r[8] && pok8_r) ? psb_pkg::pack_pixel(cfg, p_q) : 32'd0;
    end
  end

  always_comb begin
    f_addr = (it_r[6].opcode == psb_pkg::OP_FETCH) ? pos6_r : FAW'(it_r[6].frame_address);
    f_we   = v_r[6] && it_r[6].opcode == psb_pkg::OP_WR_PIX &&
             32'(it_r[6].frame_address) < 32'(FRAME);
    p_addr = (it_r[7].opcode == psb_pkg::OP_FETCH) ? f_q[PAW-1:0] :
             it_r[7].palette_slot[PAW-1:0];
    p_we   = v_r[7] && it_r[7].opcode == psb_pkg::OP_WR_PAL &&
             32'(it_r[7].palette_slot) < 32'(PALETTE_ENTRIES);
  end

  psb_ram #(.WIDTH(8), .DEPTH(FRAME)) u_frame (
    .clk   (clk),
    .en    (adv),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (it_r[6].color_index),
    .rdata (f_q)
  );

  psb_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_pal (
    .clk   (clk),
    .en    (adv),
    .we    (p_we),
    .addr  (p_addr),
    .wdata ({it_r[7].red_in, it_r[7].green_in, it_r[7].blue_in}),
    .rdata (p_q)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== rtl/palette_scaling_blitter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// nearest-neighbor scaler with palette lookup: write items fill the palette and the indexed
// source frame, fetch items return one packed framebuffer pixel each. one item per clock is
// taken while neither a stall nor a geometry recomputation holds the input; a fetch result
// passes the stages offset, source scaling, reciprocal multiply, two correction stages,
// address, frame memory, palette memory and pack. a full output register with out_ready low
// stalls the whole pipeline. after reset and after every register write, in_ready stays low
// while the target size, offsets and the two reciprocals are recomputed (the two reciprocals
// by a bit-serial divider).
module palette_scaling_blitter_core #(
  parameter int SRC_WIDTH       = 320,
  parameter int SRC_HEIGHT      = 200,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire psb_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output psb_pkg::out_t      out_item,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  psb_pkg::cfg_t  cfg_r;
  psb_pkg::geom_t geom;
  logic           busy;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scr_width    <= 12'd640;
      cfg_r.scr_height   <= 12'd400;
      cfg_r.pixel_format <= 1'b1;
      cfg_r.red_shift    <= 5'd16;
      cfg_r.green_shift  <= 5'd8;
      cfg_r.blue_shift   <= 5'd0;
      cfg_r.scale_forced <= 1'b0;
      cfg_r.scale_factor <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        psb_pkg::REG_SCR_WIDTH:    cfg_r.scr_width    <= pwdata[11:0];
        psb_pkg::REG_SCR_HEIGHT:   cfg_r.scr_height   <= pwdata[11:0];
        psb_pkg::REG_PIXEL_FORMAT: cfg_r.pixel_format <= pwdata[0];
        psb_pkg::REG_RED_SHIFT:    cfg_r.red_shift    <= pwdata[4:0];
        psb_pkg::REG_GREEN_SHIFT:  cfg_r.green_shift  <= pwdata[4:0];
        psb_pkg::REG_BLUE_SHIFT:   cfg_r.blue_shift   <= pwdata[4:0];
        psb_pkg::REG_SCALE_FORCED: cfg_r.scale_forced <= pwdata[0];
        psb_pkg::REG_SCALE_FACTOR: cfg_r.scale_factor <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      psb_pkg::REG_SCR_WIDTH:    prdata = {20'd0, cfg_r.scr_width};
      psb_pkg::REG_SCR_HEIGHT:   prdata = {20'd0, cfg_r.scr_height};
      psb_pkg::REG_PIXEL_FORMAT: prdata = {31'd0, cfg_r.pixel_format};
      psb_pkg::REG_RED_SHIFT:    prdata = {27'd0, cfg_r.red_shift};
      psb_pkg::REG_GREEN_SHIFT:  prdata = {27'd0, cfg_r.green_shift};
      psb_pkg::REG_BLUE_SHIFT:   prdata = {27'd0, cfg_r.blue_shift};
      psb_pkg::REG_SCALE_FORCED: prdata = {31'd0, cfg_r.scale_forced};
      psb_pkg::REG_SCALE_FACTOR: prdata = {27'd0, cfg_r.scale_factor};
      default:                   prdata = 32'd0;
    endcase
  end

  psb_geom #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .cfg   (cfg_r),
    .geom  (geom),
    .busy  (busy)
  );

  psb_fetch #(
    .SRC_WIDTH       (SRC_WIDTH),
    .SRC_HEIGHT      (SRC_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (busy),
    .cfg       (cfg_r),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("item taken while geometry recomputes");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready) else $error("item taken right after register write");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.in_picture |-> out_item.pixel_word == 32'd0)
    else $error("border pixel not zero");

  a_565_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cfg_r.pixel_format |-> out_item.pixel_word[31:16] == 16'd0)
    else $error("rgb565 pixel has upper bits set");

endmodule
`default_nettype wire
